// File: rtl/core/hafm_pkg.sv
// ---------------------------------------------------------------------------
// hafm_pkg: shared types and constants of the HDLC AFSK frame modulator
// Transaction payloads, configuration layout, opcodes and reset values.
// ---------------------------------------------------------------------------
package hafm_pkg;

   // Default sizes of the frame store and of the sine lookup
   localparam int FRAME_DEPTH_DEFAULT  = 128;
   localparam int SINE_ENTRIES_DEFAULT = 512;

   // Opcodes of a request transaction
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Configuration port layout
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_BIT       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARK_PHASE_STEP     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPACE_PHASE_STEP    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREAMBLE_FLAG_COUNT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REST_THRESHOLD      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRE_EMPHASIS_ON     = 3'd5;

   // Configuration reset values
   localparam logic [7:0]  TICKS_PER_BIT_RESET       = 8'd52;
   localparam logic [15:0] MARK_PHASE_STEP_RESET     = 16'd1258;
   localparam logic [15:0] SPACE_PHASE_STEP_RESET    = 16'd2306;
   localparam logic [7:0]  PREAMBLE_FLAG_COUNT_RESET = 8'd50;
   localparam logic [5:0]  REST_THRESHOLD_RESET      = 6'd5;
   localparam logic        PRE_EMPHASIS_ON_RESET     = 1'b1;

   // Framing and modulation constants
   localparam int          REST_W          = 9;
   localparam logic [7:0]  FLAG_BYTE       = 8'h7E;
   localparam logic [2:0]  STUFF_RUN       = 3'd5;
   localparam logic [2:0]  BIT_INDEX_RESET = 3'd7;
   localparam logic [15:0] CRC_PRESET      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'h8408;
   localparam logic [7:0]  SAMPLE_MIDSCALE = 8'd128;
   localparam logic [7:0]  EMPHASIS_OFFSET = 8'd64;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] sample_value;
      logic       transmitting;
      logic       push_rejected;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  ticks_per_bit;
      logic [15:0] mark_phase_step;
      logic [15:0] space_phase_step;
      logic [7:0]  preamble_flag_count;
      logic [5:0]  rest_threshold;
      logic        pre_emphasis_on;
   } cfg_type;

   // Engine to frame store: what to do this cycle
   typedef struct packed {
      logic push;
      logic start;
      logic load;
   } fs_ctrl_type;

   // Frame store to engine: fill and read status
   typedef struct packed {
      logic       room;
      logic       empty;
      logic       last;
      logic [7:0] next_byte;
   } fs_status_type;

endpackage

// File: rtl/core/hafm_ram.sv
// ---------------------------------------------------------------------------
// hafm_ram: generic single-port-write RAM
// One write and one read address per cycle, read data registered.
// ---------------------------------------------------------------------------
module hafm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = hafm_pkg::FRAME_DEPTH_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/hafm_frame_store.sv
// ---------------------------------------------------------------------------
// hafm_frame_store: frame byte buffer with running CRC
// Collects pushed bytes, keeps the reflected CRC-CCITT, latches the FCS at
// start and presents the byte at the read pointer to the bit engine.
// ---------------------------------------------------------------------------
module hafm_frame_store #(
   parameter int FRAME_DEPTH = hafm_pkg::FRAME_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              data_byte,
   input  hafm_pkg::fs_ctrl_type   ctrl,
   output hafm_pkg::fs_status_type status
);

   localparam int ADDR_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(FRAME_DEPTH - 2);

   logic [CNT_W-1:0] frame_count_ff, frame_count_in;
   logic [CNT_W-1:0] data_len_ff, data_len_in;
   logic [CNT_W-1:0] read_ptr_ff, read_ptr_in;
   logic [CNT_W-1:0] bytes_left_ff, bytes_left_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       fcs_lo_ff, fcs_lo_in;
   logic [7:0]       fcs_hi_ff, fcs_hi_in;
   logic [7:0]       ram_rd_data;

   // Fold one byte into the reflected CRC, one bit per step
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ hafm_pkg::CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   hafm_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctrl.push),
      .wr_addr (frame_count_ff[ADDR_W-1:0]),
      .wr_data (data_byte),
      .rd_addr (read_ptr_in[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Fill, start and read pointer updates
   always_comb begin
      frame_count_in = frame_count_ff;
      data_len_in    = data_len_ff;
      read_ptr_in    = read_ptr_ff;
      bytes_left_in  = bytes_left_ff;
      crc_in         = crc_ff;
      fcs_lo_in      = fcs_lo_ff;
      fcs_hi_in      = fcs_hi_ff;
      if (ctrl.push) begin
         frame_count_in = frame_count_ff + CNT_W'(1);
         crc_in         = crc_update(crc_ff, data_byte);
      end
      if (ctrl.start) begin
         fcs_lo_in      = ~crc_ff[7:0];
         fcs_hi_in      = ~crc_ff[15:8];
         data_len_in    = frame_count_ff;
         bytes_left_in  = frame_count_ff + CNT_W'(2);
         read_ptr_in    = '0;
         frame_count_in = '0;
         crc_in         = hafm_pkg::CRC_PRESET;
      end
      if (ctrl.load) begin
         read_ptr_in   = read_ptr_ff + CNT_W'(1);
         bytes_left_in = bytes_left_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         data_len_ff    <= '0;
         read_ptr_ff    <= '0;
         bytes_left_ff  <= '0;
         crc_ff         <= hafm_pkg::CRC_PRESET;
      end else begin
         frame_count_ff <= frame_count_in;
         data_len_ff    <= data_len_in;
         read_ptr_ff    <= read_ptr_in;
         bytes_left_ff  <= bytes_left_in;
         crc_ff         <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      fcs_lo_ff <= fcs_lo_in;
      fcs_hi_ff <= fcs_hi_in;
   end

   // Select frame data, then FCS low byte, then FCS high byte
   always_comb begin
      status.room  = (frame_count_ff <= ROOM_LIMIT);
      status.empty = (bytes_left_ff == '0);
      status.last  = (bytes_left_ff == CNT_W'(1));
      if (read_ptr_ff < data_len_ff) begin
         status.next_byte = ram_rd_data;
      end else if (read_ptr_ff == data_len_ff) begin
         status.next_byte = fcs_lo_ff;
      end else begin
         status.next_byte = fcs_hi_ff;
      end
   end

endmodule

// File: rtl/core/hafm_sine_rom.sv
// ---------------------------------------------------------------------------
// hafm_sine_rom: phase to sine sample lookup
// Maps a 16-bit phase to a table index and returns the 8-bit sample in the
// next cycle; the table is built at elaboration from a Q14 polynomial.
// ---------------------------------------------------------------------------
module hafm_sine_rom #(
   parameter int SINE_ENTRIES = hafm_pkg::SINE_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic [15:0] phase,
   output logic [7:0]  sample
);

   localparam int IDX_W  = $clog2(SINE_ENTRIES);
   localparam int PROD_W = 16 + IDX_W + 1;
   localparam logic [PROD_W-1:0] ENTRY_COUNT = PROD_W'(SINE_ENTRIES);

   logic [7:0]        sine_lut [SINE_ENTRIES];
   logic [PROD_W-1:0] phase_product;
   logic [IDX_W-1:0]  lut_index;
   logic [7:0]        sample_ff;

   // sin(pi/2 * t / 16384) in Q14
   function automatic int unsigned quarter_sine(input int unsigned t);
      int unsigned t2;
      int unsigned p;
      t2 = (t * t) >> 14;
      p  = 1306 - ((t2 * 77) >> 14);
      p  = 10583 - ((t2 * p) >> 14);
      p  = 25736 - ((t2 * p) >> 14);
      return (t * p) >> 14;
   endfunction

   function automatic logic [7:0] sine_value(input int unsigned idx);
      longint unsigned a64;
      int unsigned     a;
      int unsigned     q;
      int unsigned     r;
      int unsigned     t;
      int unsigned     mag;
      a64 = (64'(idx) << 16) / SINE_ENTRIES;
      a   = 32'(a64 & 64'hFFFF);
      q   = a >> 14;
      r   = a & 32'h3FFF;
      t   = q[0] ? (16384 - r) : r;
      mag = (127 * quarter_sine(t) + 8192) >> 14;
      if (mag > 127) begin
         mag = 127;
      end
      return q[1] ? 8'(128 - mag) : 8'(128 + mag);
   endfunction

   for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_lut
      assign sine_lut[g] = sine_value(g);
   end

   // Scale the phase to a table index
   assign phase_product = PROD_W'(phase) * ENTRY_COUNT;
   assign lut_index     = phase_product[16 +: IDX_W];

   always_ff @(posedge clock) begin
      sample_ff <= sine_lut[lut_index];
   end

   assign sample = sample_ff;

endmodule

// File: rtl/core/hafm_tx_engine.sv
// ---------------------------------------------------------------------------
// hafm_tx_engine: request decode, tone generator and HDLC bit engine
// Decodes push, start and tick transactions, steps the DDS phase, and at
// each baud boundary sends flags, NRZI data with zero stuffing, and rest.
// ---------------------------------------------------------------------------
module hafm_tx_engine #(
   parameter int SINE_ENTRIES = hafm_pkg::SINE_ENTRIES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  hafm_pkg::req_type       req,
   input  hafm_pkg::cfg_type       cfg,
   input  hafm_pkg::fs_status_type fs_status,
   output hafm_pkg::fs_ctrl_type   fs_ctrl,
   output hafm_pkg::rsp_type       result
);

   localparam int W = hafm_pkg::REST_W;

   logic          busy_ff, busy_in;
   logic [15:0]   phase_ff, phase_in;
   logic          space_ff, space_in;
   logic [7:0]    sample_cnt_ff, sample_cnt_in;
   logic [W-1:0]  rest_ff, rest_in;
   logic [7:0]    shift_ff, shift_in;
   logic [2:0]    bit_index_ff, bit_index_in;
   logic [2:0]    ones_ff, ones_in;
   logic          flag_ff, flag_in;
   logic [7:0]    held_ff, held_in;

   logic [7:0]    sine_sample;
   logic [7:0]    tone_sample;
   logic [7:0]    sample_cnt_inc;
   logic [W-1:0]  rest_reload;
   logic [W-1:0]  rest_dec;
   logic [2:0]    bit_next;
   logic [7:0]    shift_sel;
   logic          flag_sel;
   logic [2:0]    ones_sel;
   logic          space_sel;
   logic          stop_tx;
   logic          rejected;

   // The lookup is addressed by the next phase, so its registered sample matches phase_ff
   hafm_sine_rom #(
      .SINE_ENTRIES (SINE_ENTRIES)
   ) u_sine_rom (
      .clock  (clock),
      .phase  (phase_in),
      .sample (sine_sample)
   );

   // Halve the mark tone around midscale when pre-emphasis is on
   assign tone_sample = (cfg.pre_emphasis_on && !space_ff) ?
                        ((sine_sample >> 1) + hafm_pkg::EMPHASIS_OFFSET) : sine_sample;

   assign sample_cnt_inc = sample_cnt_ff + 8'd1;
   assign rest_reload    = W'(cfg.preamble_flag_count) + W'(cfg.rest_threshold);
   assign bit_next       = bit_index_ff + 3'd1;

   always_comb begin
      busy_in       = busy_ff;
      phase_in      = phase_ff;
      space_in      = space_ff;
      sample_cnt_in = sample_cnt_ff;
      rest_in       = rest_ff;
      shift_in      = shift_ff;
      bit_index_in  = bit_index_ff;
      ones_in       = ones_ff;
      flag_in       = flag_ff;
      held_in       = held_ff;
      fs_ctrl       = '0;
      rejected      = 1'b0;
      rest_dec      = rest_ff;
      shift_sel     = shift_ff;
      flag_sel      = flag_ff;
      ones_sel      = ones_ff;
      space_sel     = space_ff;
      stop_tx       = 1'b0;

      if (accept) begin
         case (req.opcode)
            hafm_pkg::OP_PUSH: begin
               if (busy_ff || !fs_status.room) begin
                  rejected = 1'b1;
               end else begin
                  fs_ctrl.push = 1'b1;
               end
            end
            hafm_pkg::OP_START: begin
               // Arm a new frame from the preamble
               if (!busy_ff && fs_status.room) begin
                  fs_ctrl.start = 1'b1;
                  busy_in       = 1'b1;
                  phase_in      = '0;
                  sample_cnt_in = '0;
                  space_in      = 1'b0;
                  rest_in       = rest_reload;
                  bit_index_in  = hafm_pkg::BIT_INDEX_RESET;
                  ones_in       = '0;
                  flag_in       = 1'b0;
               end
            end
            hafm_pkg::OP_TICK: begin
               if (busy_ff) begin
                  held_in       = tone_sample;
                  phase_in      = phase_ff + (space_ff ? cfg.space_phase_step
                                                        : cfg.mark_phase_step);
                  sample_cnt_in = sample_cnt_inc;
                  if (!(sample_cnt_inc < cfg.ticks_per_bit)) begin
                     sample_cnt_in = '0;
                     if (!flag_ff && ones_ff == hafm_pkg::STUFF_RUN) begin
                        // Insert the stuffed zero
                        space_in = !space_ff;
                        ones_in  = '0;
                     end else begin
                        bit_index_in = bit_next;
                        if (bit_next == 3'd0) begin
                           if (rest_ff > W'(cfg.rest_threshold) || fs_status.empty) begin
                              // Flag byte: preamble or trailing rest
                              rest_dec = (rest_ff != '0) ? (rest_ff - W'(1)) : rest_ff;
                              rest_in  = rest_dec;
                              if (rest_dec == '0) begin
                                 stop_tx = 1'b1;
                              end else begin
                                 shift_sel = hafm_pkg::FLAG_BYTE;
                                 flag_sel  = 1'b1;
                                 ones_sel  = '0;
                              end
                           end else begin
                              // Frame byte from the store
                              shift_sel    = fs_status.next_byte;
                              fs_ctrl.load = 1'b1;
                              if (fs_status.last) begin
                                 rest_in = W'(cfg.rest_threshold) + W'(2);
                              end
                              if (flag_ff) begin
                                 flag_sel = 1'b0;
                                 ones_sel = '0;
                              end
                           end
                        end
                        if (stop_tx) begin
                           // Return to idle
                           busy_in       = 1'b0;
                           phase_in      = '0;
                           sample_cnt_in = '0;
                           space_in      = 1'b0;
                           rest_in       = rest_reload;
                           bit_index_in  = hafm_pkg::BIT_INDEX_RESET;
                           ones_in       = '0;
                           flag_in       = 1'b0;
                        end else begin
                           // NRZI: a zero toggles the tone
                           if (shift_sel[0]) begin
                              if (!flag_sel) begin
                                 ones_sel = ones_sel + 3'd1;
                              end
                           end else begin
                              space_sel = !space_ff;
                              if (!flag_sel) begin
                                 ones_sel = '0;
                              end
                           end
                           shift_in = shift_sel >> 1;
                           flag_in  = flag_sel;
                           ones_in  = ones_sel;
                           space_in = space_sel;
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         phase_ff      <= '0;
         space_ff      <= 1'b0;
         sample_cnt_ff <= '0;
         rest_ff       <= W'(hafm_pkg::PREAMBLE_FLAG_COUNT_RESET) +
                          W'(hafm_pkg::REST_THRESHOLD_RESET);
         shift_ff      <= '0;
         bit_index_ff  <= hafm_pkg::BIT_INDEX_RESET;
         ones_ff       <= '0;
         flag_ff       <= 1'b0;
         held_ff       <= hafm_pkg::SAMPLE_MIDSCALE;
      end else begin
         busy_ff       <= busy_in;
         phase_ff      <= phase_in;
         space_ff      <= space_in;
         sample_cnt_ff <= sample_cnt_in;
         rest_ff       <= rest_in;
         shift_ff      <= shift_in;
         bit_index_ff  <= bit_index_in;
         ones_ff       <= ones_in;
         flag_ff       <= flag_in;
         held_ff       <= held_in;
      end
   end

   // Result of this transaction, taken into the output register
   assign result.sample_value  = held_in;
   assign result.transmitting  = busy_in;
   assign result.push_rejected = rejected;

endmodule

// File: rtl/core/hdlc_afsk_frame_modulator.sv
// ---------------------------------------------------------------------------
// hdlc_afsk_frame_modulator: AX.25 style HDLC framer with AFSK tone output
// Buffers frame bytes with CRC, then sends preamble flags, NRZI stuffed
// data and trailing flags as a sine sample per tick transaction.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  req_      in         req_valid/req_stall  hafm_pkg::req_type (opcode, data)
//  rsp_      out        rsp_valid/rsp_stall  hafm_pkg::rsp_type (sample, flags)
//  csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
//  One request transaction per cycle while req_stall is low; its result is
//  in the output register on the next cycle. The sine lookup reads the next
//  phase and the frame RAM the next read pointer, so none waits on them.
//  req_stall is high only while a result sits in the output register and
//  rsp_stall holds it. Reset is synchronous; no clearing pass is needed.
// ---------------------------------------------------------------------------
module hdlc_afsk_frame_modulator #(
   parameter int FRAME_DEPTH  = hafm_pkg::FRAME_DEPTH_DEFAULT,
   parameter int SINE_ENTRIES = hafm_pkg::SINE_ENTRIES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  hafm_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output hafm_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hafm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hafm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   hafm_pkg::cfg_type       cfg_ff, cfg_in;
   hafm_pkg::fs_ctrl_type   fs_ctrl;
   hafm_pkg::fs_status_type fs_status;
   hafm_pkg::rsp_type       result;
   hafm_pkg::rsp_type       rsp_data_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    accept;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            hafm_pkg::CSR_TICKS_PER_BIT:       cfg_in.ticks_per_bit       = csr_wdata[7:0];
            hafm_pkg::CSR_MARK_PHASE_STEP:     cfg_in.mark_phase_step     = csr_wdata;
            hafm_pkg::CSR_SPACE_PHASE_STEP:    cfg_in.space_phase_step    = csr_wdata;
            hafm_pkg::CSR_PREAMBLE_FLAG_COUNT: cfg_in.preamble_flag_count = csr_wdata[7:0];
            hafm_pkg::CSR_REST_THRESHOLD:      cfg_in.rest_threshold      = csr_wdata[5:0];
            hafm_pkg::CSR_PRE_EMPHASIS_ON:     cfg_in.pre_emphasis_on     = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_bit       <= hafm_pkg::TICKS_PER_BIT_RESET;
         cfg_ff.mark_phase_step     <= hafm_pkg::MARK_PHASE_STEP_RESET;
         cfg_ff.space_phase_step    <= hafm_pkg::SPACE_PHASE_STEP_RESET;
         cfg_ff.preamble_flag_count <= hafm_pkg::PREAMBLE_FLAG_COUNT_RESET;
         cfg_ff.rest_threshold      <= hafm_pkg::REST_THRESHOLD_RESET;
         cfg_ff.pre_emphasis_on     <= hafm_pkg::PRE_EMPHASIS_ON_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accept whenever the output register is free or being drained
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   hafm_frame_store #(
      .FRAME_DEPTH (FRAME_DEPTH)
   ) u_frame_store (
      .clock     (clock),
      .reset     (reset),
      .data_byte (req_data.data_byte),
      .ctrl      (fs_ctrl),
      .status    (fs_status)
   );

   hafm_tx_engine #(
      .SINE_ENTRIES (SINE_ENTRIES)
   ) u_tx_engine (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .cfg       (cfg_ff),
      .fs_status (fs_status),
      .fs_ctrl   (fs_ctrl),
      .result    (result)
   );

   // Output register: load on accept, hold while stalled
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/hafm_checker.sv
// ---------------------------------------------------------------------------
// hafm_checker: port-level checks of the frame modulator
// Watches the request and result channels over time.
// ---------------------------------------------------------------------------
module hafm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input hafm_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input hafm_pkg::rsp_type rsp_data
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // Every accepted transaction shows a result on the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted transaction gave no result");

   // Only a push transaction can be rejected
   a_reject_push_only: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.opcode != hafm_pkg::OP_PUSH
      |=> !rsp_data.push_rejected)
      else $error("non-push transaction flagged as rejected");

   // Stall requests only while a held result is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with a free output register");

endmodule

bind hdlc_afsk_frame_modulator hafm_checker u_checker (.*);

// File: dv/tb_hdlc_afsk_frame_modulator.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_hdlc_afsk_frame_modulator: self-checking bench for the HDLC AFSK framer
// Sends push, start and tick transactions with random gaps and random result
// stalls. It keeps its own framer, CRC and DDS model to predict every result,
// and compares each one field by field.
// ---------------------------------------------------------------------------
module tb_hdlc_afsk_frame_modulator;

   localparam int DEPTH = hafm_pkg::FRAME_DEPTH_DEFAULT;
   localparam int SINE_N = hafm_pkg::SINE_ENTRIES_DEFAULT;
   // Opcode value that the block treats as a no-op
   localparam logic [1:0] OP_NONE = 2'd3;
   localparam logic [7:0] HDLC_FLAG = 8'h7E;
   localparam logic [15:0] CCITT_POLY = 16'h8408;
   // Bytes with long runs of ones or zeros, to force stuffing and tone flips
   localparam logic [39:0] RUN_BYTES = 40'hFF_7E_1F_F8_00;
   // Longest quiet stretch: the longest request gap stacked on a few long stalls
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS = 200;
   localparam int TAIL_CYCLES = 8;
   localparam int PRINT_CAP = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   hafm_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   hafm_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [hafm_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [hafm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Settings as the modulator sees them
   logic [7:0] cfg_spb;
   logic [15:0] cfg_mark;
   logic [15:0] cfg_space;
   logic [7:0] cfg_pre;
   logic [5:0] cfg_rest;
   logic cfg_emph;

   // Framer and tone generator state
   logic [7:0] frame_mem [DEPTH];
   int unsigned fill_count;
   int unsigned rd_ptr;
   int unsigned bytes_left;
   int unsigned rest_left;
   logic [15:0] crc_acc;
   logic [15:0] phase;
   logic tone_space;
   logic [7:0] baud_count;
   logic [7:0] shifter;
   logic [2:0] bit_pos;
   logic [3:0] ones_seen;
   logic flags_on;
   logic tx_busy;
   logic [7:0] held;

   hafm_pkg::rsp_type pending_samples[$];
   int mismatch_count = 0;
   int useful_items = 0;
   int burst_left = 0;
   int stall_hold = 0;
   int idle_cycles = 0;

   hdlc_afsk_frame_modulator uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Sine table entry: Q14 quarter-wave polynomial, mirrored per quadrant
   function automatic logic [7:0] tone_level(input int unsigned idx);
      int unsigned ang, quad, frac, t, t2, p, mag;
      ang = ((idx << 16) / SINE_N) & 32'hFFFF;
      quad = ang >> 14;
      frac = ang & 32'h3FFF;
      t = ((quad & 1) != 0) ? 16384 - frac : frac;
      t2 = (t * t) >> 14;
      p = 1306 - ((t2 * 77) >> 14);
      p = 10583 - ((t2 * p) >> 14);
      p = 25736 - ((t2 * p) >> 14);
      p = (t * p) >> 14;
      mag = (127 * p + 8192) >> 14;
      if (mag > 127) mag = 127;
      return ((quad & 2) != 0) ? 8'(128 - mag) : 8'(128 + mag);
   endfunction

   // Reflected CRC-CCITT over one byte
   function automatic logic [15:0] crc_update(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      for (int k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ CCITT_POLY) : (c >> 1);
      return c;
   endfunction

   // Drop back to idle with the tone generator cleared
   function automatic void close_frame();
      tx_busy = 1'b0;
      phase = '0;
      baud_count = '0;
      tone_space = 1'b0;
      rest_left = cfg_pre + cfg_rest;
      bit_pos = 3'd7;
      ones_seen = '0;
      flags_on = 1'b0;
   endfunction

   function automatic void reset_model();
      cfg_spb = 8'd52;
      cfg_mark = 16'd1258;
      cfg_space = 16'd2306;
      cfg_pre = 8'd50;
      cfg_rest = 6'd5;
      cfg_emph = 1'b1;
      fill_count = 0;
      rd_ptr = 0;
      bytes_left = 0;
      crc_acc = 16'hFFFF;
      shifter = '0;
      held = 8'd128;
      close_frame();
   endfunction

   // One sample of the running frame, and the bit clock behind it
   function automatic void advance_sample();
      int unsigned idx;
      logic [7:0] level;
      idx = phase;
      idx = (idx * SINE_N) >> 16;
      level = tone_level(idx % SINE_N);
      if (cfg_emph && !tone_space) level = (level >> 1) + 8'd64;
      held = level;
      phase = phase + (tone_space ? cfg_space : cfg_mark);

      baud_count = baud_count + 8'd1;
      if (baud_count < cfg_spb) return;
      baud_count = '0;

      // Stuffed zero after five data ones
      if (!flags_on && ones_seen == 4'd5) begin
         tone_space = ~tone_space;
         ones_seen = '0;
         return;
      end

      bit_pos = bit_pos + 3'd1;
      if (bit_pos == 3'd0) begin
         if (rest_left > cfg_rest || bytes_left == 0) begin
            if (rest_left > 0) rest_left = rest_left - 1;
            if (rest_left == 0) begin
               close_frame();
               return;
            end
            shifter = HDLC_FLAG;
            flags_on = 1'b1;
            ones_seen = '0;
         end else begin
            shifter = (rd_ptr < DEPTH) ? frame_mem[rd_ptr] : 8'h00;
            rd_ptr = rd_ptr + 1;
            bytes_left = bytes_left - 1;
            if (bytes_left == 0) rest_left = cfg_rest + 2;
            if (flags_on) begin
               flags_on = 1'b0;
               ones_seen = '0;
            end
         end
      end

      // NRZI: a zero flips the tone
      if (shifter[0]) begin
         if (!flags_on) ones_seen = ones_seen + 4'd1;
      end else begin
         tone_space = ~tone_space;
         if (!flags_on) ones_seen = '0;
      end
      shifter = shifter >> 1;
   endfunction

   // Expected result of one accepted transaction
   function automatic hafm_pkg::rsp_type modulate_item(input hafm_pkg::req_type item);
      hafm_pkg::rsp_type r;
      logic dropped;
      dropped = 1'b0;
      case (item.opcode)
         hafm_pkg::OP_PUSH: begin
            if (tx_busy || fill_count + 2 > DEPTH) begin
               dropped = 1'b1;
            end else begin
               frame_mem[fill_count] = item.data_byte;
               fill_count = fill_count + 1;
               crc_acc = crc_update(crc_acc, item.data_byte);
            end
         end
         hafm_pkg::OP_START: begin
            if (!tx_busy && fill_count + 2 <= DEPTH) begin
               frame_mem[fill_count] = ~crc_acc[7:0];
               frame_mem[fill_count + 1] = ~crc_acc[15:8];
               bytes_left = fill_count + 2;
               rd_ptr = 0;
               fill_count = 0;
               crc_acc = 16'hFFFF;
               close_frame();
               tx_busy = 1'b1;
            end
         end
         hafm_pkg::OP_TICK: begin
            if (tx_busy) advance_sample();
         end
         default: ;
      endcase
      r.sample_value = held;
      r.transmitting = tx_busy;
      r.push_rejected = dropped;
      return r;
   endfunction

   function automatic void apply_setting(input logic [hafm_pkg::CSR_INDEX_W-1:0] idx,
                                         input logic [hafm_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         hafm_pkg::CSR_TICKS_PER_BIT: cfg_spb = value[7:0];
         hafm_pkg::CSR_MARK_PHASE_STEP: cfg_mark = value;
         hafm_pkg::CSR_SPACE_PHASE_STEP: cfg_space = value;
         hafm_pkg::CSR_PREAMBLE_FLAG_COUNT: begin
            cfg_pre = value[7:0];
            if (!tx_busy) rest_left = cfg_pre + cfg_rest;
         end
         hafm_pkg::CSR_REST_THRESHOLD: begin
            cfg_rest = value[5:0];
            if (!tx_busy) rest_left = cfg_pre + cfg_rest;
         end
         hafm_pkg::CSR_PRE_EMPHASIS_ON: cfg_emph = value[0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------

   // Mostly back to back, some short gaps, a few long ones, and calm bursts
   function automatic int next_gap();
      int pick;
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         burst_left = $urandom_range(30, 150);
         return 0;
      end
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Send one transaction; valid stays high on return so the next call can
   // follow in the same cycle
   task automatic issue(input logic [1:0] op, input logic [7:0] value);
      int gap;
      hafm_pkg::req_type item;
      gap = next_gap();
      item.opcode = op;
      item.data_byte = value;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      if (op == hafm_pkg::OP_PUSH || (op == hafm_pkg::OP_START && !tx_busy)
          || (op == hafm_pkg::OP_TICK && tx_busy))
         useful_items++;
      pending_samples.push_back(modulate_item(item));
   endtask

   // Lower valid and wait until every result is back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_samples.size() != 0);
   endtask

   task automatic write_setting(input logic [hafm_pkg::CSR_INDEX_W-1:0] idx,
                                input logic [hafm_pkg::CSR_DATA_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_setting(idx, value);
   endtask

   task automatic run_ticks(input int count);
      repeat (count) issue(hafm_pkg::OP_TICK, 8'($urandom));
   endtask

   task automatic run_to_idle();
      while (tx_busy) issue(hafm_pkg::OP_TICK, 8'($urandom));
   endtask

   // Result stalls: mostly short, a few long, with calm stretches
   always @(posedge clock) begin
      int pick;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            rsp_stall <= 1'b0;
            stall_hold <= (pick < 5) ? $urandom_range(50, 200) : $urandom_range(0, 6);
         end else begin
            rsp_stall <= 1'b1;
            stall_hold <= (pick > 96) ? $urandom_range(20, 60) : $urandom_range(0, 2);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      // keep the log short when everything goes wrong
      if (mismatch_count <= PRINT_CAP)
         $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      hafm_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            report_mismatch("unexpected result", int'(rsp_data), 0);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_data.sample_value !== want.sample_value)
               report_mismatch("sample_value", int'(rsp_data.sample_value),
                               int'(want.sample_value));
            if (rsp_data.transmitting !== want.transmitting)
               report_mismatch("transmitting", int'(rsp_data.transmitting),
                               int'(want.transmitting));
            if (rsp_data.push_rejected !== want.push_rejected)
               report_mismatch("push_rejected", int'(rsp_data.push_rejected),
                               int'(want.push_rejected));
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Idle ticks, no-op, pushes at the byte extremes, then a frame at reset
   // settings with a push and a start while it is running
   task automatic test_idle_and_defaults();
      issue(hafm_pkg::OP_TICK, 8'hFF);
      issue(OP_NONE, 8'h00);
      issue(hafm_pkg::OP_PUSH, 8'h00);
      issue(hafm_pkg::OP_PUSH, 8'hFF);
      issue(hafm_pkg::OP_PUSH, 8'h5A);
      issue(hafm_pkg::OP_PUSH, 8'h81);
      issue(hafm_pkg::OP_START, 8'hC3);
      issue(hafm_pkg::OP_PUSH, 8'h3C);
      issue(hafm_pkg::OP_START, 8'h00);
      issue(OP_NONE, 8'hA5);
      run_ticks(60);
   endtask

   // Change the bit rate and preamble mid-frame; preamble must not reload
   task automatic test_setting_change_in_frame();
      write_setting(hafm_pkg::CSR_TICKS_PER_BIT, 16'd0);
      write_setting(hafm_pkg::CSR_PREAMBLE_FLAG_COUNT, 16'd1);
      run_to_idle();
   endtask

   // Start with nothing pushed: only the two CRC bytes go out
   task automatic test_empty_frame();
      write_setting(hafm_pkg::CSR_TICKS_PER_BIT, 16'd1);
      write_setting(hafm_pkg::CSR_PREAMBLE_FLAG_COUNT, 16'd2);
      write_setting(hafm_pkg::CSR_REST_THRESHOLD, 16'd1);
      write_setting(hafm_pkg::CSR_PRE_EMPHASIS_ON, 16'd0);
      write_setting(hafm_pkg::CSR_MARK_PHASE_STEP, 16'hFFFF);
      write_setting(hafm_pkg::CSR_SPACE_PHASE_STEP, 16'd0);
      issue(hafm_pkg::OP_START, 8'h00);
      run_to_idle();
   endtask

   // Runs of ones that need a stuffed zero, including flag-like data
   task automatic test_bit_stuffing();
      write_setting(hafm_pkg::CSR_MARK_PHASE_STEP, 16'd1258);
      write_setting(hafm_pkg::CSR_SPACE_PHASE_STEP, 16'd2306);
      write_setting(hafm_pkg::CSR_PRE_EMPHASIS_ON, 16'd1);
      write_setting(hafm_pkg::CSR_TICKS_PER_BIT, 16'd2);
      issue(hafm_pkg::OP_PUSH, 8'hFF);
      issue(hafm_pkg::OP_PUSH, 8'hFF);
      issue(hafm_pkg::OP_PUSH, 8'h7E);
      issue(hafm_pkg::OP_PUSH, 8'h1F);
      issue(hafm_pkg::OP_PUSH, 8'hF8);
      issue(hafm_pkg::OP_PUSH, 8'h3E);
      issue(hafm_pkg::OP_PUSH, 8'h7C);
      issue(hafm_pkg::OP_START, 8'hFF);
      run_to_idle();
   endtask

   // Fill the store past its room; the tail pushes must be dropped
   task automatic test_store_overflow();
      write_setting(hafm_pkg::CSR_TICKS_PER_BIT, 16'd1);
      write_setting(hafm_pkg::CSR_PREAMBLE_FLAG_COUNT, 16'd1);
      repeat (DEPTH + 2) issue(hafm_pkg::OP_PUSH, 8'($urandom));
      issue(hafm_pkg::OP_START, 8'($urandom));
      run_to_idle();
   endtask

   // Slowest bit clock and extreme tone steps across a baud boundary,
   // then speed up the bit clock so the frame ends
   task automatic test_extreme_settings();
      write_setting(hafm_pkg::CSR_TICKS_PER_BIT, 16'd255);
      write_setting(hafm_pkg::CSR_PRE_EMPHASIS_ON, 16'd0);
      write_setting(hafm_pkg::CSR_MARK_PHASE_STEP, 16'd0);
      write_setting(hafm_pkg::CSR_SPACE_PHASE_STEP, 16'hFFFF);
      issue(hafm_pkg::OP_PUSH, 8'h00);
      issue(hafm_pkg::OP_PUSH, 8'hFF);
      issue(hafm_pkg::OP_START, 8'h00);
      run_ticks(280);
      write_setting(hafm_pkg::CSR_TICKS_PER_BIT, 16'd1);
      run_to_idle();
   endtask

   // Random settings and frames, with stray transactions mixed in
   task automatic test_random_frames();
      int goal, nbytes, pick;
      goal = useful_items + RANDOM_ITEMS;
      write_setting(hafm_pkg::CSR_PREAMBLE_FLAG_COUNT, 16'd2);
      write_setting(hafm_pkg::CSR_REST_THRESHOLD, 16'd2);
      while (useful_items < goal) begin
         // new settings between frames
         if ($urandom_range(0, 1) != 0)
            write_setting(hafm_pkg::CSR_TICKS_PER_BIT, 16'(($urandom_range(0, 9) == 0) ?
                          $urandom_range(4, 8) : $urandom_range(0, 3)));
         if ($urandom_range(0, 2) == 0)
            write_setting(hafm_pkg::CSR_MARK_PHASE_STEP, 16'($urandom_range(0, 65535)));
         if ($urandom_range(0, 2) == 0)
            write_setting(hafm_pkg::CSR_SPACE_PHASE_STEP, 16'($urandom_range(0, 65535)));
         if ($urandom_range(0, 3) == 0)
            write_setting(hafm_pkg::CSR_PREAMBLE_FLAG_COUNT, 16'($urandom_range(1, 4)));
         if ($urandom_range(0, 3) == 0)
            write_setting(hafm_pkg::CSR_REST_THRESHOLD, 16'($urandom_range(1, 4)));
         if ($urandom_range(0, 3) == 0)
            write_setting(hafm_pkg::CSR_PRE_EMPHASIS_ON, 16'($urandom_range(0, 1)));

         // load the frame, with idle noise between pushes
         nbytes = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
         repeat (nbytes) begin
            if ($urandom_range(0, 9) == 0)
               issue(($urandom_range(0, 1) != 0) ? hafm_pkg::OP_TICK : OP_NONE,
                     8'($urandom));
            pick = $urandom_range(0, 9);
            if (pick < 3) issue(hafm_pkg::OP_PUSH, RUN_BYTES[8 * $urandom_range(0, 4) +: 8]);
            else issue(hafm_pkg::OP_PUSH, 8'($urandom));
         end

         // most frames go out; the rest carry their bytes into the next one
         if ($urandom_range(0, 9) != 0) begin
            issue(hafm_pkg::OP_START, 8'($urandom));
            while (tx_busy) begin
               pick = $urandom_range(0, 39);
               if (pick == 0) issue(hafm_pkg::OP_PUSH, 8'($urandom));
               else if (pick == 1) issue(hafm_pkg::OP_START, 8'($urandom));
               else if (pick == 2) issue(OP_NONE, 8'($urandom));
               else issue(hafm_pkg::OP_TICK, 8'($urandom));
            end
         end
      end
   endtask

   initial begin
      reset_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_idle_and_defaults();
      test_setting_change_in_frame();
      test_empty_frame();
      test_bit_stuffing();
      test_store_overflow();
      test_extreme_settings();
      test_random_frames();

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_samples.size() != 0)
         report_mismatch("results never arrived", pending_samples.size(), 0);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
